// File: rtl/imucan_pkg.sv
// ----------------------------------------------------------------------------
// imucan_pkg: shared definitions for the IMU CAN frame receiver
// Operation codes, result kinds, register indexes, reset values and widths.
// ----------------------------------------------------------------------------
`default_nettype none

package imucan_pkg;

   // Field widths
   localparam int unsigned ID_W      = 11;
   localparam int unsigned TICK_W    = 16;
   localparam int unsigned CODE_W    = 8;
   localparam int unsigned OP_W      = 2;
   localparam int unsigned KIND_W    = 3;
   localparam int unsigned COUNT_W   = 4;
   localparam int unsigned PAYLOAD_W = 64;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 16;

   // Item operations
   localparam logic [OP_W-1:0] OP_FRAME     = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK      = 2'd1;
   localparam logic [OP_W-1:0] OP_ID_CHANGE = 2'd2;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INVALID = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ACCEL   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_GYRO    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EULER   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_QUAT    = 3'd5;
   localparam logic [KIND_W-1:0] KIND_RESP    = 3'd6;

   // First-byte selectors and response separator
   localparam logic [7:0] HDR_ACCEL = 8'h01;
   localparam logic [7:0] HDR_GYRO  = 8'h02;
   localparam logic [7:0] HDR_EULER = 8'h03;
   localparam logic [7:0] HDR_QUAT  = 8'h04;
   localparam logic [7:0] HDR_CMD   = 8'hcc;
   localparam logic [7:0] CMD_SEP   = 8'hdd;

   // Valid data length
   localparam logic [COUNT_W-1:0] FULL_LENGTH = 4'd8;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_DEVICE_ID = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_REPLY_ID  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFLINE_TICKS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_REG     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLY_REG      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_SUCCESS    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_LAST       = 3'd6;

   // Register reset values
   localparam logic [ID_W-1:0]   RST_DEVICE_ID    = 11'd1;
   localparam logic [ID_W-1:0]   RST_REPLY_ID     = 11'd17;
   localparam logic [TICK_W-1:0] RST_OFFLINE      = 16'd1;
   localparam logic [CODE_W-1:0] RST_DEVICE_REG   = 8'd8;
   localparam logic [CODE_W-1:0] RST_REPLY_REG    = 8'd9;
   localparam logic [CODE_W-1:0] RST_ACK_SUCCESS  = 8'd1;
   localparam logic [CODE_W-1:0] RST_ACK_LAST     = 8'd2;

endpackage

`default_nettype wire

// File: rtl/imu_can_frame_receiver.sv
// ----------------------------------------------------------------------------
// imu_can_frame_receiver: decode frames from a CAN-attached IMU
// Tracks the sensor identifiers, the online status and decodes data frames.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per handshake: a received frame, a timer tick, or
//   the note that an identifier-change command went out. rsp_* returns one
//   result per item, in order, with the decoded fields and the status after
//   that item. Both channels use valid/ready.
//   csr_* writes a register at any edge with csr_we high; write only while
//   no item is in flight. Writing an initial id loads the current id at once.
//   An accepted item is held in the input register and decoded into the
//   result register once that is free or being read, raising rsp_valid.
//   Throughput: one item per cycle while rsp_ready is high. The input register
//   and the result register form a two-stage pipe; the status update sits
//   between them. When rsp_ready is low the result holds, one more item waits
//   in the input register, and req_ready drops only while both are full and
//   rsp_ready is low.
//   Reset (synchronous, active high) loads the register defaults, the
//   current ids from them, clears pending ids and marks the sensor offline.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_can_frame_receiver (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // Input items
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [imucan_pkg::OP_W-1:0]            req_op,
   input  wire logic [imucan_pkg::ID_W-1:0]            req_frame_id,
   input  wire logic                                   req_is_extended,
   input  wire logic                                   req_is_remote,
   input  wire logic [imucan_pkg::COUNT_W-1:0]         req_byte_count,
   input  wire logic [imucan_pkg::PAYLOAD_W-1:0]       req_payload,
   input  wire logic                                   req_change_which,
   input  wire logic [imucan_pkg::ID_W-1:0]            req_change_value,
   // Result items
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [imucan_pkg::KIND_W-1:0]               rsp_packet_kind,
   output logic [15:0]                                 rsp_field_w,
   output logic [15:0]                                 rsp_field_x,
   output logic [15:0]                                 rsp_field_y,
   output logic [31:0]                                 rsp_field_z,
   output logic                                        rsp_online,
   output logic [imucan_pkg::ID_W-1:0]                 rsp_device_id,
   output logic [imucan_pkg::ID_W-1:0]                 rsp_reply_id,
   // Register writes
   input  wire logic                                   csr_we,
   input  wire logic [imucan_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [imucan_pkg::CSR_DAT_W-1:0]       csr_wdata
);

   localparam int unsigned ID_W   = imucan_pkg::ID_W;
   localparam int unsigned TICK_W = imucan_pkg::TICK_W;
   localparam int unsigned CODE_W = imucan_pkg::CODE_W;
   localparam int unsigned KIND_W = imucan_pkg::KIND_W;

   // Configuration registers
   logic [TICK_W-1:0] offline_ticks_ff;
   logic [CODE_W-1:0] device_reg_ff, reply_reg_ff, ack_success_ff, ack_last_ff;

   // Receiver status
   logic [ID_W-1:0]   cur_device_id_ff, cur_device_id_in;
   logic [ID_W-1:0]   cur_reply_id_ff, cur_reply_id_in;
   logic [ID_W-1:0]   pend_device_id_ff, pend_device_id_in;
   logic [ID_W-1:0]   pend_reply_id_ff, pend_reply_id_in;
   logic              pend_device_valid_ff, pend_device_valid_in;
   logic              pend_reply_valid_ff, pend_reply_valid_in;
   logic              alive_ff, alive_in;
   logic [TICK_W-1:0] countdown_ff, countdown_in;
   logic              seen_ff, seen_in;

   // Input register
   logic                                   s1_valid_ff;
   logic [imucan_pkg::OP_W-1:0]            s1_op_ff;
   logic [ID_W-1:0]                        s1_frame_id_ff;
   logic                                   s1_ext_ff, s1_rem_ff;
   logic [imucan_pkg::COUNT_W-1:0]         s1_count_ff;
   logic [imucan_pkg::PAYLOAD_W-1:0]       s1_payload_ff;
   logic                                   s1_which_ff;
   logic [ID_W-1:0]                        s1_value_ff;

   // Result register
   logic              out_valid_ff;
   logic [KIND_W-1:0] out_kind_ff, kind_in;
   logic [15:0]       out_w_ff, out_x_ff, out_y_ff, fw_in, fx_in, fy_in;
   logic [31:0]       out_z_ff, fz_in;
   logic              out_online_ff;
   logic [ID_W-1:0]   out_device_ff, out_reply_ff;

   logic              advance;
   logic [TICK_W-1:0] timeout;
   logic [7:0]        b0, b1, b2, b3, b4, b5, b6, b7;
   logic              id_match, pend_match, good_format;

   // Handshake: the decode stage moves when the result register frees up
   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   assign timeout = (offline_ticks_ff == '0) ? TICK_W'(1) : offline_ticks_ff;

   assign b0 = s1_payload_ff[7:0];
   assign b1 = s1_payload_ff[15:8];
   assign b2 = s1_payload_ff[23:16];
   assign b3 = s1_payload_ff[31:24];
   assign b4 = s1_payload_ff[39:32];
   assign b5 = s1_payload_ff[47:40];
   assign b6 = s1_payload_ff[55:48];
   assign b7 = s1_payload_ff[63:56];

   assign id_match    = (s1_frame_id_ff == cur_reply_id_ff);
   assign pend_match  = pend_reply_valid_ff && (s1_frame_id_ff == pend_reply_id_ff);
   assign good_format = !s1_ext_ff && !s1_rem_ff &&
                        (s1_count_ff == imucan_pkg::FULL_LENGTH);

   // Decode one item and work out the status after it
   always_comb begin
      cur_device_id_in     = cur_device_id_ff;
      cur_reply_id_in      = cur_reply_id_ff;
      pend_device_id_in    = pend_device_id_ff;
      pend_reply_id_in     = pend_reply_id_ff;
      pend_device_valid_in = pend_device_valid_ff;
      pend_reply_valid_in  = pend_reply_valid_ff;
      alive_in             = alive_ff;
      countdown_in         = countdown_ff;
      seen_in              = seen_ff;
      kind_in              = imucan_pkg::KIND_NONE;
      fw_in                = '0;
      fx_in                = '0;
      fy_in                = '0;
      fz_in                = '0;

      case (s1_op_ff)
         imucan_pkg::OP_FRAME: begin
            if (id_match || pend_match) begin
               kind_in = imucan_pkg::KIND_INVALID;
               if (good_format) begin
                  if (b0 == imucan_pkg::HDR_ACCEL || b0 == imucan_pkg::HDR_GYRO ||
                      b0 == imucan_pkg::HDR_EULER) begin
                     kind_in = KIND_W'(b0 + 8'd1);
                     fw_in   = (b0 == imucan_pkg::HDR_ACCEL) ? {8'h00, b1} : '0;
                     fx_in   = {b3, b2};
                     fy_in   = {b5, b4};
                     fz_in   = {16'h0000, b7, b6};
                  end else if (b0 == imucan_pkg::HDR_QUAT) begin
                     // Unpack four 14-bit components packed big-endian
                     kind_in = imucan_pkg::KIND_QUAT;
                     fw_in   = {2'b00, b1, b2[7:2]};
                     fx_in   = {2'b00, b2[1:0], b3, b4[7:4]};
                     fy_in   = {2'b00, b4[3:0], b5, b6[7:6]};
                     fz_in   = {18'h00000, b6[5:0], b7};
                  end else if (b0 == imucan_pkg::HDR_CMD) begin
                     if (b2 == imucan_pkg::CMD_SEP && b3 <= ack_last_ff) begin
                        kind_in = imucan_pkg::KIND_RESP;
                        fw_in   = {8'h00, b1};
                        fx_in   = {8'h00, b3};
                        fz_in   = s1_payload_ff[63:32];
                        // Commit or drop a pending id; device code wins a tie
                        if (b1 == device_reg_ff) begin
                           if (b3 == ack_success_ff && pend_device_valid_ff)
                              cur_device_id_in = pend_device_id_ff;
                           pend_device_valid_in = 1'b0;
                        end else if (b1 == reply_reg_ff) begin
                           if (b3 == ack_success_ff && pend_reply_valid_ff)
                              cur_reply_id_in = pend_reply_id_ff;
                           pend_reply_valid_in = 1'b0;
                        end
                     end
                  end
               end
               // A decoded frame keeps the sensor online
               if (kind_in >= imucan_pkg::KIND_ACCEL) begin
                  if (pend_match && kind_in != imucan_pkg::KIND_RESP) begin
                     cur_reply_id_in     = pend_reply_id_ff;
                     pend_reply_valid_in = 1'b0;
                  end
                  seen_in      = 1'b1;
                  alive_in     = 1'b1;
                  countdown_in = timeout;
               end
            end
         end
         imucan_pkg::OP_TICK: begin
            if (seen_ff) begin
               alive_in     = 1'b1;
               countdown_in = timeout;
            end else if (countdown_ff != '0) begin
               countdown_in = countdown_ff - TICK_W'(1);
            end
            if (countdown_in == '0)
               alive_in = 1'b0;
            seen_in = 1'b0;
         end
         imucan_pkg::OP_ID_CHANGE: begin
            if (!s1_which_ff) begin
               pend_device_id_in    = s1_value_ff;
               pend_device_valid_in = 1'b1;
            end else begin
               pend_reply_id_in    = s1_value_ff;
               pend_reply_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         offline_ticks_ff <= imucan_pkg::RST_OFFLINE;
         device_reg_ff    <= imucan_pkg::RST_DEVICE_REG;
         reply_reg_ff     <= imucan_pkg::RST_REPLY_REG;
         ack_success_ff   <= imucan_pkg::RST_ACK_SUCCESS;
         ack_last_ff      <= imucan_pkg::RST_ACK_LAST;
      end else if (csr_we) begin
         unique case (csr_index)
            imucan_pkg::CSR_OFFLINE_TICKS: offline_ticks_ff <= csr_wdata;
            imucan_pkg::CSR_DEVICE_REG:    device_reg_ff    <= csr_wdata[CODE_W-1:0];
            imucan_pkg::CSR_REPLY_REG:     reply_reg_ff     <= csr_wdata[CODE_W-1:0];
            imucan_pkg::CSR_ACK_SUCCESS:   ack_success_ff   <= csr_wdata[CODE_W-1:0];
            imucan_pkg::CSR_ACK_LAST:      ack_last_ff      <= csr_wdata[CODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Update status; an id register write overrides the item update
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_device_id_ff     <= imucan_pkg::RST_DEVICE_ID;
         cur_reply_id_ff      <= imucan_pkg::RST_REPLY_ID;
         pend_device_id_ff    <= '0;
         pend_reply_id_ff     <= '0;
         pend_device_valid_ff <= 1'b0;
         pend_reply_valid_ff  <= 1'b0;
         alive_ff             <= 1'b0;
         countdown_ff         <= '0;
         seen_ff              <= 1'b0;
      end else begin
         if (advance) begin
            cur_device_id_ff     <= cur_device_id_in;
            cur_reply_id_ff      <= cur_reply_id_in;
            pend_device_id_ff    <= pend_device_id_in;
            pend_reply_id_ff     <= pend_reply_id_in;
            pend_device_valid_ff <= pend_device_valid_in;
            pend_reply_valid_ff  <= pend_reply_valid_in;
            alive_ff             <= alive_in;
            countdown_ff         <= countdown_in;
            seen_ff              <= seen_in;
         end
         if (csr_we && csr_index == imucan_pkg::CSR_INIT_DEVICE_ID) begin
            cur_device_id_ff     <= csr_wdata[ID_W-1:0];
            pend_device_valid_ff <= 1'b0;
         end
         if (csr_we && csr_index == imucan_pkg::CSR_INIT_REPLY_ID) begin
            cur_reply_id_ff     <= csr_wdata[ID_W-1:0];
            pend_reply_valid_ff <= 1'b0;
         end
      end
   end

   // Capture an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_op_ff       <= req_op;
         s1_frame_id_ff <= req_frame_id;
         s1_ext_ff      <= req_is_extended;
         s1_rem_ff      <= req_is_remote;
         s1_count_ff    <= req_byte_count;
         s1_payload_ff  <= req_payload;
         s1_which_ff    <= req_change_which;
         s1_value_ff    <= req_change_value;
      end
   end

   // Load the result register, hold it while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_kind_ff   <= kind_in;
         out_w_ff      <= fw_in;
         out_x_ff      <= fx_in;
         out_y_ff      <= fy_in;
         out_z_ff      <= fz_in;
         out_online_ff <= alive_in;
         out_device_ff <= cur_device_id_in;
         out_reply_ff  <= cur_reply_id_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_packet_kind = out_kind_ff;
   assign rsp_field_w     = out_w_ff;
   assign rsp_field_x     = out_x_ff;
   assign rsp_field_y     = out_y_ff;
   assign rsp_field_z     = out_z_ff;
   assign rsp_online      = out_online_ff;
   assign rsp_device_id   = out_device_ff;
   assign rsp_reply_id    = out_reply_ff;

   // Online status always has ticks left to run
   a_online_count: assert property (@(posedge clock) disable iff (reset)
      alive_ff |-> countdown_ff != '0)
      else $error("online with zero countdown");

   // An initial device id write drops the pending device id
   a_dev_write_drop: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_index == imucan_pkg::CSR_INIT_DEVICE_ID |=> !pend_device_valid_ff)
      else $error("pending device id survived initial id write");

   // An initial reply id write drops the pending reply id
   a_rep_write_drop: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_index == imucan_pkg::CSR_INIT_REPLY_ID |=> !pend_reply_valid_ff)
      else $error("pending reply id survived initial id write");

   // A decoded item lands in an empty result register
   a_advance_fill: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_valid_ff |=> out_valid_ff)
      else $error("decoded item did not reach the result register");

   // An empty result register never blocks the input
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_ready)
      else $error("input stalled with empty result register");

endmodule

`default_nettype wire
